>>> design/zzr_pkg.sv
// zzr_pkg: shared types and constants for the zigzag rail reorder block
// holds payload structs, field widths and the control state enum
// no dependencies
`default_nettype none

package zzr_pkg;

   localparam int CHAR_W     = 8;
   localparam int RAIL_W     = 6;
   localparam int RAIL_CNT_W = 7;
   localparam int RAIL_LIMIT = 64;

   typedef struct packed {
      logic [CHAR_W-1:0] in_char;
      logic              in_last;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              out_last;
      logic              overflowed;
   } rsp_payload_type;

   typedef enum logic {
      ST_LOAD,
      ST_SCAN
   } ctrl_state_type;

endpackage

`default_nettype wire

>>> design/zigzag_rail_reorder.sv
// zigzag_rail_reorder: rail fence encoder, one byte per beat in, reordered bytes out
// path: an accepted byte is written to the message memory; after the last byte, emission
//   passes the scan state, the memory read register and the output register in that order
// throughput: loading accepts one byte per cycle; emission reads the message memory once per
//   stored byte for each rail up to the highest rail holding an unsent byte, one read port
// reset: synchronous, clears message state and sets the rail count to 1; memory is not cleared
`default_nettype none

module zigzag_rail_reorder #(
   parameter int MAX_LEN = 64
) (
   input  wire                       clock,
   input  wire                       reset,
   // request channel
   input  wire                       req_valid,
   output logic                      req_stall,
   input  zzr_pkg::req_payload_type  req_data,
   // response channel
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output zzr_pkg::rsp_payload_type  rsp_data,
   // rail count register write
   input  wire                       csr_valid,
   output logic                      csr_ready,
   input  wire [zzr_pkg::RAIL_CNT_W-1:0] csr_data
);
   import zzr_pkg::*;

   localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int FW    = $clog2(MAX_LEN + 1);
   localparam int ENT_W = RAIL_W + CHAR_W;

   // message memory: rail tag over byte
   logic [ENT_W-1:0] mem_ff [MAX_LEN];
   logic [ENT_W-1:0] rd_data_ff;
   logic [RAIL_W-1:0] rd_rail_ff;

   ctrl_state_type         state_ff, state_in;
   logic [RAIL_CNT_W-1:0]  rail_count_ff, rail_count_in;
   logic [FW-1:0]          fill_ff, fill_in;
   logic [RAIL_W-1:0]      cur_rail_ff, cur_rail_in;
   logic                   going_up_ff, going_up_in;
   logic                   ovf_ff, ovf_in;
   logic [RAIL_W-1:0]      scan_rail_ff, scan_rail_in;
   logic [AW-1:0]          scan_idx_ff, scan_idx_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic [FW-1:0]          emit_cnt_ff, emit_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   logic                   req_fire;
   logic                   store_full;
   logic                   wr_en;
   logic                   rd_en;
   logic [RAIL_W-1:0]      top_rail;
   logic                   gu_turn;
   logic [RAIL_W-1:0]      adv_rail;
   logic                   adv_up;
   logic                   out_free;
   logic                   rd_match;
   logic                   rd_consume;
   logic                   load_out;
   logic                   msg_done;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign req_fire   = req_valid && !req_stall;
   assign store_full = (fill_ff == FW'(MAX_LEN));
   assign wr_en      = req_fire && !store_full;

   // top rail from the register: zero means one rail, above the limit saturates
   always_comb begin
      if (rail_count_ff == '0) begin
         top_rail = '0;
      end else if (rail_count_ff > RAIL_CNT_W'(RAIL_LIMIT)) begin
         top_rail = RAIL_W'(RAIL_LIMIT - 1);
      end else begin
         top_rail = RAIL_W'(rail_count_ff - RAIL_CNT_W'(1));
      end
   end

   // zigzag step for the next byte
   always_comb begin
      gu_turn  = going_up_ff;
      adv_up   = going_up_ff;
      adv_rail = cur_rail_ff;
      if (top_rail == '0) begin
         adv_rail = '0;
      end else begin
         if (cur_rail_ff >= top_rail) begin
            gu_turn = 1'b0;
         end else if (cur_rail_ff == '0) begin
            gu_turn = 1'b1;
         end
         adv_up = gu_turn;
         if (gu_turn) begin
            adv_rail = cur_rail_ff + RAIL_W'(1);
         end else if (cur_rail_ff != '0) begin
            adv_rail = cur_rail_ff - RAIL_W'(1);
         end
      end
   end

   // scan handshake between memory read data and the output register
   // the pending read is matched against the rail it was issued for
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rd_match   = rd_pend_ff && (rd_data_ff[ENT_W-1:CHAR_W] == rd_rail_ff);
   assign rd_consume = rd_pend_ff && (!rd_match || out_free);
   assign load_out   = (state_ff == ST_SCAN) && rd_match && out_free;
   assign msg_done   = load_out && ((emit_cnt_ff + FW'(1)) == fill_ff);
   assign rd_en      = (state_ff == ST_SCAN) && (!rd_pend_ff || rd_consume) && !msg_done;

   // next state and datapath control
   always_comb begin
      state_in      = state_ff;
      rail_count_in = rail_count_ff;
      fill_in       = fill_ff;
      cur_rail_in   = cur_rail_ff;
      going_up_in   = going_up_ff;
      ovf_in        = ovf_ff;
      scan_rail_in  = scan_rail_ff;
      scan_idx_in   = scan_idx_ff;
      rd_pend_in    = rd_pend_ff;
      emit_cnt_in   = emit_cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (csr_valid && csr_ready) begin
         rail_count_in = csr_data;
      end

      // output register drains independently of the scan
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (store_full) begin
                  ovf_in = 1'b1;
               end else begin
                  fill_in     = fill_ff + FW'(1);
                  cur_rail_in = adv_rail;
                  going_up_in = adv_up;
               end
               if (req_data.in_last) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_consume) begin
               rd_pend_in = 1'b0;
            end
            if (load_out) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.out_char = rd_data_ff[CHAR_W-1:0];
               rsp_data_in.out_last = msg_done;
               rsp_data_in.overflowed = ovf_ff;
               emit_cnt_in          = emit_cnt_ff + FW'(1);
            end
            if (rd_en) begin
               rd_pend_in = 1'b1;
               if ((FW'(scan_idx_ff) + FW'(1)) == fill_ff) begin
                  scan_idx_in  = '0;
                  scan_rail_in = scan_rail_ff + RAIL_W'(1);
               end else begin
                  scan_idx_in = scan_idx_ff + AW'(1);
               end
            end
            // every stored byte sent: clear for the next message
            if (msg_done) begin
               state_in     = ST_LOAD;
               fill_in      = '0;
               cur_rail_in  = '0;
               going_up_in  = 1'b0;
               ovf_in       = 1'b0;
               scan_rail_in = '0;
               scan_idx_in  = '0;
               rd_pend_in   = 1'b0;
               emit_cnt_in  = '0;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         rail_count_ff <= RAIL_CNT_W'(1);
         fill_ff       <= '0;
         cur_rail_ff   <= '0;
         going_up_ff   <= 1'b0;
         ovf_ff        <= 1'b0;
         scan_rail_ff  <= '0;
         scan_idx_ff   <= '0;
         rd_pend_ff    <= 1'b0;
         emit_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rail_count_ff <= rail_count_in;
         fill_ff       <= fill_in;
         cur_rail_ff   <= cur_rail_in;
         going_up_ff   <= going_up_in;
         ovf_ff        <= ovf_in;
         scan_rail_ff  <= scan_rail_in;
         scan_idx_ff   <= scan_idx_in;
         rd_pend_ff    <= rd_pend_in;
         emit_cnt_ff   <= emit_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // message memory write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[fill_ff[AW-1:0]] <= {cur_rail_ff, req_data.in_char};
      end
   end

   // registered message memory read port, with the rail being scanned
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[scan_idx_ff];
         rd_rail_ff <= scan_rail_ff;
      end
   end

`ifndef SYNTHESIS
   // never more bytes sent than stored
   a_emit_le_fill: assert property (@(posedge clock) disable iff (reset)
      emit_cnt_ff <= fill_ff)
      else $error("emit count passed fill count");

   // store never grows past capacity
   a_fill_cap: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(MAX_LEN))
      else $error("fill count beyond capacity");

   // a scan always has at least one stored byte
   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (fill_ff != '0))
      else $error("scan with empty store");

   // the final beat of a message returns the block to loading
   a_last_ends_scan: assert property (@(posedge clock) disable iff (reset)
      msg_done |=> (state_ff == ST_LOAD) && (fill_ff == '0))
      else $error("message did not end after final beat");
`endif

endmodule

`default_nettype wire

>>> test/rail_order_checker.sv
// rail_order_checker: watches the request, response and rail count channels of the
// zigzag rail reorder block, predicts the reordered bytes and compares them beat by beat
// depends on zzr_pkg for the payload structs and widths
module rail_order_checker #(
   parameter int MAX_LEN = 64
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   input  wire                           req_stall,
   input  zzr_pkg::req_payload_type      req_data,
   input  wire                           rsp_valid,
   input  wire                           rsp_stall,
   input  zzr_pkg::rsp_payload_type      rsp_data,
   input  wire                           csr_valid,
   input  wire                           csr_ready,
   input  wire [zzr_pkg::RAIL_CNT_W-1:0] csr_data,
   output int                            fail_count,
   output int                            outstanding
);
   import zzr_pkg::*;

   // reordered bytes still owed by the block, oldest first
   rsp_payload_type bytes_due[$];

   // shadow of the block: rail count register and the message being loaded
   logic [RAIL_CNT_W-1:0] rail_setting;
   logic [CHAR_W-1:0]     char_mem [MAX_LEN];
   logic [RAIL_W-1:0]     rail_mem [MAX_LEN];
   int                    fill;
   logic [RAIL_W-1:0]     next_rail;
   logic                  climbing;
   logic                  dropped;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // zero counts as one rail, anything past the limit saturates
   function automatic int rows_in_use();
      int r;
      r = int'(rail_setting);
      if (r == 0) r = 1;
      if (r > RAIL_LIMIT) r = RAIL_LIMIT;
      return r;
   endfunction

   // move to the rail of the following byte
   task automatic step_zigzag();
      int rows;
      rows = rows_in_use();
      if (rows <= 1) begin
         next_rail = '0;
      end else begin
         if (int'(next_rail) >= rows - 1) begin
            climbing = 1'b0;
         end else if (next_rail == '0) begin
            climbing = 1'b1;
         end
         if (climbing) begin
            next_rail = next_rail + 1'b1;
         end else if (next_rail != '0) begin
            next_rail = next_rail - 1'b1;
         end
      end
   endtask

   task automatic clear_message();
      fill      = 0;
      next_rail = '0;
      climbing  = 1'b0;
      dropped   = 1'b0;
   endtask

   // store one accepted byte; on the last byte queue the whole message rail by rail
   task automatic take_byte(input req_payload_type beat);
      rsp_payload_type item;
      int              emitted;
      emitted = 0;
      if (fill < MAX_LEN) begin
         char_mem[fill] = beat.in_char;
         rail_mem[fill] = next_rail;
         fill++;
         step_zigzag();
      end else begin
         dropped = 1'b1;
      end
      if (beat.in_last) begin
         // every stored rail is below the limit, so all fill bytes come out
         for (int rail = 0; rail < RAIL_LIMIT; rail++) begin
            for (int i = 0; i < fill; i++) begin
               if (int'(rail_mem[i]) == rail) begin
                  item.out_char   = char_mem[i];
                  item.out_last   = (emitted == fill - 1);
                  item.overflowed = dropped;
                  bytes_due.push_back(item);
                  emitted++;
               end
            end
         end
         clear_message();
      end
   endtask

   // compare one response beat with the oldest owed byte
   task automatic check_beat(input rsp_payload_type got);
      rsp_payload_type want;
      if (bytes_due.size() == 0) begin
         $error("unexpected response beat: out_char %0h out_last %0b overflowed %0b",
                got.out_char, got.out_last, got.overflowed);
         fail_count++;
      end else begin
         want = bytes_due.pop_front();
         if (got.out_char !== want.out_char) begin
            $error("out_char mismatch: expected %0h actual %0h", want.out_char, got.out_char);
            fail_count++;
         end
         if (got.out_last !== want.out_last) begin
            $error("out_last mismatch: expected %0b actual %0b", want.out_last, got.out_last);
            fail_count++;
         end
         if (got.overflowed !== want.overflowed) begin
            $error("overflowed mismatch: expected %0b actual %0b",
                   want.overflowed, got.overflowed);
            fail_count++;
         end
      end
   endtask

   // sample all three channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         rail_setting = 7'd1;
         clear_message();
         bytes_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_beat(rsp_data);
         if (csr_valid && csr_ready) rail_setting = csr_data;
         if (req_valid && !req_stall) take_byte(req_data);
      end
      outstanding = bytes_due.size();
   end

endmodule

>>> test/tb_top.sv
// tb_top: drives messages and rail count writes into the zigzag rail reorder block
// with random idling on both sides; rail_order_checker predicts and compares the output
// depends on zzr_pkg, zigzag_rail_reorder and rail_order_checker
module tb_top;
   import zzr_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int SETTLE       = 8;
   localparam int HOLD_CYCLES  = 500;
   localparam int RANDOM_BEATS = 140;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_payload_type       req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [RAIL_CNT_W-1:0] csr_data = '0;
   int                    fail_count;
   int                    outstanding;
   bit                    hold_rsp = 1'b0;
   int                    random_beats = 0;

   zigzag_rail_reorder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   rail_order_checker rail_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #HALF_PERIOD clock = ~clock;
   end

   // idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // offer one byte after a random gap and wait until it is taken
   task automatic send_beat(input logic [CHAR_W-1:0] ch, input logic last_flag);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_data.in_char <= ch;
      req_data.in_last <= last_flag;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid and let every owed beat drain before touching the register
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_rails(input logic [RAIL_CNT_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // random message; optionally change the rail count partway through
   task automatic send_message(input int len, input int split_at,
                               input logic [RAIL_CNT_W-1:0] split_rails);
      for (int i = 0; i < len; i++) begin
         if (i == split_at) begin
            settle();
            write_rails(split_rails);
         end
         send_beat(8'($urandom_range(0, 255)), i == len - 1);
      end
   endtask

   // receiver: random stall runs, plus one long hold on request
   initial begin
      int n;
      forever begin
         if (hold_rsp) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         n = pick_gap();
         if (n > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (n - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         repeat ($urandom_range(0, 10)) @(negedge clock);
      end
   end

   // stimulus and verdict
   initial begin
      logic [CHAR_W-1:0]     mixed [7];
      int                    msg_idx;
      int                    len;
      int                    split_at;
      logic [RAIL_CNT_W-1:0] split_rails;
      mixed = '{8'h20, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA};
      msg_idx = 0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset rail count of one: bytes pass in order
      send_beat(8'hFF, 1'b0);
      send_beat(8'h00, 1'b1);

      // three rails, one-byte message, then bytes near the extremes and a space
      settle();
      write_rails(7'd3);
      send_beat(8'h41, 1'b1);
      foreach (mixed[i]) send_beat(mixed[i], i == 6);

      // zero rails behaves as one
      settle();
      write_rails(7'd0);
      send_message(3, -1, '0);

      // five rails, then drop to two mid-message with the rail above the new top
      settle();
      write_rails(7'd5);
      send_message(9, 5, 7'd2);

      // random messages with fixed settings first, including an overflow and a long hold
      while (random_beats < RANDOM_BEATS) begin
         split_at    = -1;
         split_rails = '0;
         len         = $urandom_range(1, 16);
         // the message after the held one is offered without waiting for drain
         if (msg_idx != 3) begin
            settle();
            case (msg_idx)
               0: write_rails(7'd64);
               1: write_rails(7'd127);
               2: write_rails(7'd65);
               4: write_rails(7'd1);
               5: write_rails(7'd2);
               default: begin
                  if ($urandom_range(0, 2) == 0) begin
                     if ($urandom_range(0, 1) == 0) write_rails(7'($urandom_range(0, 127)));
                     else write_rails(7'($urandom_range(1, 8)));
                  end
               end
            endcase
         end
         if (msg_idx == 0) len = 66;
         if (msg_idx == 2) begin
            len      = 24;
            hold_rsp = 1'b1;
         end
         if (msg_idx > 3 && len >= 4 && $urandom_range(0, 5) == 0) begin
            split_at    = $urandom_range(1, len - 1);
            split_rails = 7'($urandom_range(0, 127));
         end
         send_message(len, split_at, split_rails);
         random_beats += len;
         msg_idx++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0) begin
         $display("zigzag_rail_reorder verification clean");
      end else begin
         $display("zigzag_rail_reorder verification failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #3000000;
      $display("zigzag_rail_reorder verification failed");
      $finish;
   end

endmodule

>>> files.f
design/zzr_pkg.sv
design/zigzag_rail_reorder.sv
test/rail_order_checker.sv
test/tb_top.sv
